// ===== rtl/wmrm_pkg.sv =====
// Package for the windowed mismatch rate monitor.
// Shared constants, decision and register codes, and the configuration struct.
// No dependencies.
`default_nettype none

package wmrm_pkg;

  localparam int WINDOW_DEF = 256;
  localparam int MID_DEPTH  = 2;
  localparam int OUT_DEPTH  = 4;

  localparam int OUT_CW    = 9;   // width of the reported counts
  localparam int DEC_W     = 3;
  localparam int MIN_W     = 13;  // observation / mismatch minimums
  localparam int RATE_W    = 17;  // Q1.16 rate thresholds, below 2.0
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 17;

  localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);

  typedef enum logic [DEC_W-1:0] {
    DEC_INSUFFICIENT = 3'd0,
    DEC_ACTIVATE     = 3'd1,
    DEC_REJECT       = 3'd2,
    DEC_REOPEN       = 3'd3,
    DEC_HEALTHY      = 3'd4
  } dec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIVE_PHASE      = 3'd0,
    CFG_SHADOW_MIN_OBS  = 3'd1,
    CFG_ACT_MAX_RATE    = 3'd2,
    CFG_LIVE_MIN_OBS    = 3'd3,
    CFG_REOPEN_MIN_MM   = 3'd4,
    CFG_REOPEN_RATE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              live_phase;
    logic [MIN_W-1:0]  shadow_min_obs;
    logic [RATE_W-1:0] act_max_rate;
    logic [MIN_W-1:0]  live_min_obs;
    logic [MIN_W-1:0]  reopen_min_mm;
    logic [RATE_W-1:0] reopen_rate;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/wmrm_queue.sv =====
// Small first-in first-out queue with registered storage.
// Used between front and back and as the result queue. Depends on nothing.
`default_nettype none

module wmrm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         pop,
  output logic [WIDTH-1:0]             rdata,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]    level_r, level_nxt;
  logic             do_push, do_pop;

  assign empty   = (level_r == '0);
  assign full    = (level_r == LW'(DEPTH));
  assign level   = level_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wmrm_front.sv =====
// Front end: takes observations, keeps the mismatch ring and window counts.
// Emits updated counts per observation. No package dependencies.
`default_nettype none

module wmrm_front #(
  parameter int WINDOW = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          expected_bit,
  input  logic                          actual_bit,
  output logic [$clog2(WINDOW+1)-1:0]   obs_nxt,
  output logic [$clog2(WINDOW+1)-1:0]   mm_nxt
);

  localparam int WAW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW  = $clog2(WINDOW + 1);

  logic           ring_r [WINDOW];
  logic [WAW-1:0] wptr_r, wptr_nxt;
  logic [WAW-1:0] raddr;
  logic           old_bit_r;   // always holds ring_r[wptr_r]
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [CW-1:0]  mm_r, mm_nxt_int;
  logic           bit_in;
  logic           full_win;
  logic           drop_bit;

  assign bit_in   = expected_bit ^ actual_bit;
  assign full_win = (fill_r == CW'(WINDOW));
  assign drop_bit = full_win && old_bit_r;

  always_comb begin
    wptr_nxt   = wptr_r;
    fill_nxt   = fill_r;
    mm_nxt_int = mm_r;
    if (accept) begin
      wptr_nxt   = (wptr_r == WAW'(WINDOW - 1)) ? '0 : wptr_r + 1'b1;
      fill_nxt   = full_win ? fill_r : fill_r + 1'b1;
      mm_nxt_int = mm_r - CW'(drop_bit) + CW'(bit_in);
    end
  end

  assign obs_nxt = fill_nxt;
  assign mm_nxt  = mm_nxt_int;
  assign raddr   = !rst_n ? '0 : wptr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      fill_r <= '0;
      mm_r   <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      fill_r <= fill_nxt;
      mm_r   <= mm_nxt_int;
    end
  end

  // ring entries are only read once the window has filled, so no clearing pass
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_r[wptr_r] <= bit_in;
    end
    if (accept && (raddr == wptr_r)) begin
      old_bit_r <= bit_in;
    end else begin
      old_bit_r <= ring_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wmrm_back.sv =====
// Back end: multiplies threshold by count, then compares and forms the decision.
// Depends on wmrm_pkg.
`default_nettype none

module wmrm_back #(
  parameter int WINDOW = 256
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  wmrm_pkg::cfg_t                               cfg,
  input  logic                                         src_valid,
  input  logic [$clog2(WINDOW+1)-1:0]                  src_obs,
  input  logic [$clog2(WINDOW+1)-1:0]                  src_mm,
  output logic                                         src_pop,
  input  logic [$clog2(wmrm_pkg::OUT_DEPTH+1)-1:0]     dst_level,
  output logic                                         dst_push,
  output logic [wmrm_pkg::OUT_CW-1:0]                  dst_obs,
  output logic [wmrm_pkg::OUT_CW-1:0]                  dst_mm,
  output wmrm_pkg::dec_t                               dst_dec
);

  localparam int CW   = $clog2(WINDOW + 1);
  localparam int PW   = wmrm_pkg::RATE_W + CW;
  localparam int CMPW = (CW > wmrm_pkg::MIN_W) ? CW : wmrm_pkg::MIN_W;
  localparam int LW   = $clog2(wmrm_pkg::OUT_DEPTH + 1);

  logic                          a_v_r;
  logic [CW-1:0]                 a_obs_r;
  logic [CW-1:0]                 a_mm_r;
  logic [PW-1:0]                 a_prod_r, prod_nxt;
  logic                          a_short_r, short_nxt;
  logic                          a_mok_r, mok_nxt;
  logic                          a_live_r;
  logic [wmrm_pkg::RATE_W-1:0]   thr;
  logic [wmrm_pkg::MIN_W-1:0]    obs_min;
  logic [PW-1:0]                 m_scaled;
  logic                          rate_le, rate_ge;
  logic [LW:0]                   committed;

  // result queue slots already spoken for
  assign committed = (LW+1)'(dst_level) + (LW+1)'(a_v_r);
  assign src_pop   = src_valid && (committed < (LW+1)'(wmrm_pkg::OUT_DEPTH));

  always_comb begin
    thr       = cfg.live_phase ? cfg.reopen_rate : cfg.act_max_rate;
    obs_min   = cfg.live_phase ? cfg.live_min_obs : cfg.shadow_min_obs;
    prod_nxt  = PW'(thr) * PW'(src_obs);
    short_nxt = CMPW'(src_obs) < CMPW'(obs_min);
    mok_nxt   = CMPW'(src_mm) >= CMPW'(cfg.reopen_min_mm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= src_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (src_pop) begin
      a_obs_r   <= src_obs;
      a_mm_r    <= src_mm;
      a_prod_r  <= prod_nxt;
      a_short_r <= short_nxt;
      a_mok_r   <= mok_nxt;
      a_live_r  <= cfg.live_phase;
    end
  end

  assign m_scaled = PW'(a_mm_r) << wmrm_pkg::FRAC_W;
  assign rate_le  = m_scaled <= a_prod_r;
  assign rate_ge  = m_scaled >= a_prod_r;

  always_comb begin
    if (a_short_r) begin
      dst_dec = wmrm_pkg::DEC_INSUFFICIENT;
    end else if (!a_live_r) begin
      dst_dec = rate_le ? wmrm_pkg::DEC_ACTIVATE : wmrm_pkg::DEC_REJECT;
    end else begin
      dst_dec = (a_mok_r && rate_ge) ? wmrm_pkg::DEC_REOPEN : wmrm_pkg::DEC_HEALTHY;
    end
  end

  assign dst_push = a_v_r;
  assign dst_obs  = wmrm_pkg::OUT_CW'(a_obs_r);
  assign dst_mm   = wmrm_pkg::OUT_CW'(a_mm_r);

endmodule

`default_nettype wire

// ===== rtl/windowed_mismatch_rate_monitor_unit.sv =====
// Top level of the windowed mismatch rate monitor: configuration registers,
// front end, count queue, back end and result queue.
// Depends on wmrm_pkg, wmrm_queue, wmrm_front and wmrm_back.
//
// Usage:
//   Input queue side: drive in_expected_bit/in_actual_bit with in_push; the
//   observation is taken at an edge where in_push is high and in_full low.
//   Result queue side: while out_empty is low the oldest result is on the
//   out_ ports; it is taken at an edge where out_pop is high.
//   Each observation gives one result: counts in the window after it and the
//   audit decision under the current phase.
//   A result passes the count queue, the back-end register and the result queue.
//   Throughput: one observation per cycle while in_full is low, set by the ring
//   update (one memory write, one prefetched read per cycle) and one 17 x 9 multiply.
//   Stall: a held result backs up the four-entry result queue, then the
//   two-entry count queue, and then in_full rises.
//   Reset: counts, pointers and queues clear synchronously; the ring is not
//   swept, its entries are used only once the window has filled.
//   Configuration: write with cfg_we/cfg_index/cfg_data while idle; writes to
//   unknown indexes are dropped.
`default_nettype none

module windowed_mismatch_rate_monitor_unit #(
  parameter int WINDOW = wmrm_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic                             in_expected_bit,
  input  logic                             in_actual_bit,
  output logic                             in_full,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [wmrm_pkg::OUT_CW-1:0]      out_observed_count,
  output logic [wmrm_pkg::OUT_CW-1:0]      out_mismatch_count,
  output logic [wmrm_pkg::DEC_W-1:0]       out_decision,
  input  logic                             cfg_we,
  input  logic [wmrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wmrm_pkg::CFG_DW-1:0]      cfg_data
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int RW  = 2 * wmrm_pkg::OUT_CW + wmrm_pkg::DEC_W;
  localparam int OLW = $clog2(wmrm_pkg::OUT_DEPTH + 1);

  wmrm_pkg::cfg_t  cfg_r, cfg_nxt;
  logic            accept;
  logic [CW-1:0]   f_obs, f_mm;
  logic [CW-1:0]   q_obs, q_mm;
  logic            q_empty, q_pop;
  logic [OLW-1:0]  o_level;
  logic            r_push;
  logic [wmrm_pkg::OUT_CW-1:0] r_obs, r_mm;
  wmrm_pkg::dec_t  r_dec;
  logic [RW-1:0]   r_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        wmrm_pkg::CFG_LIVE_PHASE:     cfg_nxt.live_phase     = cfg_data[0];
        wmrm_pkg::CFG_SHADOW_MIN_OBS: cfg_nxt.shadow_min_obs = cfg_data[wmrm_pkg::MIN_W-1:0];
        wmrm_pkg::CFG_ACT_MAX_RATE:   cfg_nxt.act_max_rate   = cfg_data;
        wmrm_pkg::CFG_LIVE_MIN_OBS:   cfg_nxt.live_min_obs   = cfg_data[wmrm_pkg::MIN_W-1:0];
        wmrm_pkg::CFG_REOPEN_MIN_MM:  cfg_nxt.reopen_min_mm  = cfg_data[wmrm_pkg::MIN_W-1:0];
        wmrm_pkg::CFG_REOPEN_RATE:    cfg_nxt.reopen_rate    = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{live_phase: 1'b0, shadow_min_obs: '0, act_max_rate: '0,
                 live_min_obs: '0, reopen_min_mm: '0,
                 reopen_rate: wmrm_pkg::ONE_Q16};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign accept = in_push && !in_full;

  wmrm_front #(.WINDOW(WINDOW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .expected_bit (in_expected_bit),
    .actual_bit   (in_actual_bit),
    .obs_nxt      (f_obs),
    .mm_nxt       (f_mm)
  );

  wmrm_queue #(.WIDTH(2 * CW), .DEPTH(wmrm_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata ({f_obs, f_mm}),
    .pop   (q_pop),
    .rdata ({q_obs, q_mm}),
    .empty (q_empty),
    .full  (in_full),
    .level ()
  );

  wmrm_back #(.WINDOW(WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .src_valid (!q_empty),
    .src_obs   (q_obs),
    .src_mm    (q_mm),
    .src_pop   (q_pop),
    .dst_level (o_level),
    .dst_push  (r_push),
    .dst_obs   (r_obs),
    .dst_mm    (r_mm),
    .dst_dec   (r_dec)
  );

  wmrm_queue #(.WIDTH(RW), .DEPTH(wmrm_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .wdata ({r_obs, r_mm, r_dec}),
    .pop   (out_pop),
    .rdata (r_head),
    .empty (out_empty),
    .full  (),
    .level (o_level)
  );

  assign out_observed_count = r_head[RW-1 -: wmrm_pkg::OUT_CW];
  assign out_mismatch_count = r_head[wmrm_pkg::DEC_W +: wmrm_pkg::OUT_CW];
  assign out_decision       = r_head[wmrm_pkg::DEC_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/wmrm_checker.sv =====
// Port-level checker for the windowed mismatch rate monitor, bound to the top.
// Depends on wmrm_pkg and windowed_mismatch_rate_monitor_unit.
`default_nettype none

module wmrm_port_checks #(
  parameter int WINDOW = wmrm_pkg::WINDOW_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_push,
  input logic                             in_full,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic [wmrm_pkg::OUT_CW-1:0]      out_observed_count,
  input logic [wmrm_pkg::OUT_CW-1:0]      out_mismatch_count,
  input logic [wmrm_pkg::DEC_W-1:0]       out_decision
);

  localparam bit UNMASKED = (WINDOW < 512);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared by reset");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_observed_count)
      && $stable(out_mismatch_count) && $stable(out_decision)))
    else $error("waiting result changed");

  a_mm_le_obs: assert property (@(posedge clk) disable iff (!rst_n)
    (UNMASKED && !out_empty) |-> (out_mismatch_count <= out_observed_count))
    else $error("mismatch count above observed count");

  a_obs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (UNMASKED && !out_empty) |->
      ((out_observed_count != '0) && (out_observed_count <= WINDOW)))
    else $error("observed count out of window range");

endmodule

bind windowed_mismatch_rate_monitor_unit wmrm_port_checks #(.WINDOW(WINDOW)) u_wmrm_checker (.*);

`default_nettype wire

// ===== dv/wmrm_checker.sv =====
// Scoreboard for the windowed mismatch rate monitor: tracks register writes,
// predicts window counts and audit decision per request, compares results.
// Depends on wmrm_pkg.
module wmrm_checker import wmrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_expected_bit,
  input  logic                 in_actual_bit,
  input  logic                 in_full,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [OUT_CW-1:0]    out_observed_count,
  input  logic [OUT_CW-1:0]    out_mismatch_count,
  input  logic [DEC_W-1:0]     out_decision,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_CW-1:0] observed;
    logic [OUT_CW-1:0] mismatches;
    dec_t              decision;
  } audit_t;

  audit_t                audit_q[$];
  audit_t                want;
  logic [WINDOW_DEF-1:0] miss_history;
  int unsigned           wr_ptr;
  int unsigned           fill;
  int unsigned           miss_total;
  cfg_t                  regs;

  function automatic dec_t audit_decision(int unsigned obs, int unsigned miss);
    longint unsigned miss_scaled;
    longint unsigned thr_scaled;
    miss_scaled = longint'(miss) << FRAC_W;
    if (!regs.live_phase) begin
      if (obs < regs.shadow_min_obs) return DEC_INSUFFICIENT;
      thr_scaled = longint'(regs.act_max_rate) * obs;
      return (obs == 0 || miss_scaled <= thr_scaled) ? DEC_ACTIVATE : DEC_REJECT;
    end
    if (obs < regs.live_min_obs) return DEC_INSUFFICIENT;
    thr_scaled = longint'(regs.reopen_rate) * obs;
    if (miss >= regs.reopen_min_mm &&
        ((obs == 0) ? (regs.reopen_rate == 0) : (miss_scaled >= thr_scaled)))
      return DEC_REOPEN;
    return DEC_HEALTHY;
  endfunction

  function automatic audit_t observe(logic miss);
    audit_t r;
    if (fill >= WINDOW_DEF) begin
      if (miss_history[wr_ptr] && miss_total > 0) miss_total--;
    end else begin
      fill++;
    end
    miss_history[wr_ptr] = miss;
    miss_total += miss;
    wr_ptr = (wr_ptr == WINDOW_DEF - 1) ? 0 : wr_ptr + 1;
    r.observed   = OUT_CW'(fill);
    r.mismatches = OUT_CW'(miss_total);
    r.decision   = audit_decision(fill, miss_total);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      audit_q.delete();
      miss_history = '0;
      wr_ptr = 0;
      fill = 0;
      miss_total = 0;
      regs = '0;
      regs.reopen_rate = ONE_Q16;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIVE_PHASE:     regs.live_phase = cfg_data[0];
          CFG_SHADOW_MIN_OBS: regs.shadow_min_obs = cfg_data[MIN_W-1:0];
          CFG_ACT_MAX_RATE:   regs.act_max_rate = cfg_data[RATE_W-1:0];
          CFG_LIVE_MIN_OBS:   regs.live_min_obs = cfg_data[MIN_W-1:0];
          CFG_REOPEN_MIN_MM:  regs.reopen_min_mm = cfg_data[MIN_W-1:0];
          CFG_REOPEN_RATE:    regs.reopen_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        audit_q.push_back(observe(in_expected_bit ^ in_actual_bit));
      if (out_pop && !out_empty) begin
        if (audit_q.size() == 0) begin
          $error("result popped with no request pending");
          fail_count++;
        end else begin
          want = audit_q.pop_front();
          if (out_observed_count !== want.observed) begin
            $error("observed_count: expected %0d, actual %0d",
                   want.observed, out_observed_count);
            fail_count++;
          end
          if (out_mismatch_count !== want.mismatches) begin
            $error("mismatch_count: expected %0d, actual %0d",
                   want.mismatches, out_mismatch_count);
            fail_count++;
          end
          if (out_decision !== want.decision) begin
            $error("decision: expected %0d, actual %0d", want.decision, out_decision);
            fail_count++;
          end
        end
      end
    end
    pending = audit_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the mismatch rate monitor testbench: clock, reset, request and
// register stimulus, result-side backpressure and the verdict.
// Depends on wmrm_pkg, windowed_mismatch_rate_monitor_unit and wmrm_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wmrm_pkg::*;

  localparam int ITEMS       = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RATE_MAX    = (1 << RATE_W) - 1;
  localparam int MIN_MAX     = (1 << MIN_W) - 1;
  localparam int ONE_RATE    = 1 << FRAC_W;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_expected_bit = 1'b0;
  logic                 in_actual_bit = 1'b0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [OUT_CW-1:0]    out_observed_count;
  logic [OUT_CW-1:0]    out_mismatch_count;
  logic [DEC_W-1:0]     out_decision;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int unsigned          cycles = 0;
  int unsigned          pop_stall = 0;
  bit                   calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  windowed_mismatch_rate_monitor_unit u_top (
    .clk, .rst_n, .in_push, .in_expected_bit, .in_actual_bit, .in_full,
    .out_empty, .out_pop, .out_observed_count, .out_mismatch_count,
    .out_decision, .cfg_we, .cfg_index, .cfg_data
  );

  wmrm_checker u_checker (
    .clk, .rst_n, .in_push, .in_expected_bit, .in_actual_bit, .in_full,
    .out_empty, .out_pop, .out_observed_count, .out_mismatch_count,
    .out_decision, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("windowed_mismatch_rate_monitor_unit regression: fail");
      $finish;
    end
  end

  // result side: random stall bursts unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_stall != 0) begin
      pop_stall = pop_stall - 1;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop_stall = $urandom_range(0, 11);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  task automatic send_request(input logic exp_b, input logic act_b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_expected_bit <= exp_b;
    in_actual_bit <= act_b;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_min();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return 257;
      4: return MIN_MAX;
      5: return $urandom_range(0, 300);
      default: return $urandom_range(0, MIN_MAX);
    endcase
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return ONE_RATE;
      2: return RATE_MAX;
      3: return $urandom_range(0, 256) * 256;
      4: return $urandom_range(0, ONE_RATE);
      default: return $urandom_range(0, RATE_MAX);
    endcase
  endfunction

  // upper data bits above a 13-bit register are noise the block must drop
  function automatic logic [CFG_DW-1:0] with_noise(input int unsigned val);
    return (CFG_DW'($urandom_range(0, 15)) << MIN_W) | CFG_DW'(val[MIN_W-1:0]);
  endfunction

  task automatic configure(input int phase);
    logic        live;
    int unsigned shadow_min, act_rate, live_min, reopen_mm, reopen_thr;
    live       = 1'($urandom_range(0, 1));
    shadow_min = pick_min();
    act_rate   = pick_rate();
    live_min   = pick_min();
    reopen_mm  = pick_min();
    reopen_thr = pick_rate();
    case (phase)
      0: begin live = 1'b0; shadow_min = MIN_MAX; act_rate = RATE_MAX; end
      1: begin live = 1'b0; shadow_min = 0; act_rate = 0; end
      2: begin live = 1'b1; live_min = 0; reopen_mm = 0; reopen_thr = 0; end
      3: begin live = 1'b1; live_min = MIN_MAX; end
      4: begin live = 1'b1; live_min = 1; reopen_mm = MIN_MAX; reopen_thr = ONE_RATE; end
      5: begin live = 1'b0; shadow_min = 256; act_rate = ONE_RATE; end
      6: begin live = 1'b1; live_min = 256; reopen_mm = 1; reopen_thr = RATE_MAX; end
      default: ;
    endcase
    write_reg(CFG_LIVE_PHASE, (CFG_DW'($urandom_range(0, 65535)) << 1) | CFG_DW'(live));
    write_reg(CFG_SHADOW_MIN_OBS, with_noise(shadow_min));
    write_reg(CFG_ACT_MAX_RATE, CFG_DW'(act_rate));
    write_reg(CFG_LIVE_MIN_OBS, with_noise(live_min));
    write_reg(CFG_REOPEN_MIN_MM, with_noise(reopen_mm));
    write_reg(CFG_REOPEN_RATE, CFG_DW'(reopen_thr));
    write_reg(CFG_IDX_W'($urandom_range(CFG_REOPEN_RATE + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DW'($urandom_range(0, RATE_MAX)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          sent;
    int          phase;
    int unsigned batch;
    int unsigned miss_pct;
    logic        exp_b;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, every bit pair
    for (int i = 0; i < 16; i++) send_request(i[0], i[1]);

    sent = 0;
    for (phase = 0; sent < ITEMS; phase++) begin
      settle();
      configure(phase);
      calm = (sent >= ITEMS - 150) || ($urandom_range(0, 4) == 0);
      batch = $urandom_range(60, 130);
      case ($urandom_range(0, 4))
        0: miss_pct = 0;
        1: miss_pct = 100;
        2: miss_pct = $urandom_range(0, 10);
        3: miss_pct = $urandom_range(40, 60);
        default: miss_pct = $urandom_range(0, 100);
      endcase
      repeat (batch) begin
        exp_b = 1'($urandom_range(0, 1));
        send_request(exp_b, exp_b ^ ($urandom_range(0, 99) < miss_pct));
      end
      sent += batch;
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("windowed_mismatch_rate_monitor_unit regression: pass");
    else
      $display("windowed_mismatch_rate_monitor_unit regression: fail");
    $finish;
  end

endmodule
